### sv/lns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_pkg: shared types and constants of the letterbox scaler
// Size widths, register indexes, divider operand selects and the
// controller-to-datapath command and status words.
// ----------------------------------------------------------------------------
package lns_pkg;

  localparam int SIZE_W  = 13;
  localparam int PROD_W  = 2 * SIZE_W;
  localparam int SRC_W   = PROD_W + 1;
  localparam int PIX_W   = 24;
  localparam int INDEX_W = 16;
  localparam int REG_W   = 2;

  localparam logic [REG_W-1:0] REG_SCREEN_W = 2'd0;
  localparam logic [REG_W-1:0] REG_SCREEN_H = 2'd1;
  localparam logic [REG_W-1:0] REG_IMAGE_W  = 2'd2;
  localparam logic [REG_W-1:0] REG_IMAGE_H  = 2'd3;

  localparam logic [SIZE_W-1:0] RST_SCREEN_W = 13'd800;
  localparam logic [SIZE_W-1:0] RST_SCREEN_H = 13'd480;
  localparam logic [SIZE_W-1:0] RST_IMAGE_W  = 13'd256;
  localparam logic [SIZE_W-1:0] RST_IMAGE_H  = 13'd256;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    DIV_EXT,
    DIV_SX,
    DIV_SY
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     prod;
    logic     frac;
    logic     div_start;
    div_sel_e div_sel;
    logic     ext_latch;
    logic     offs;
    logic     chk;
    logic     sx_latch;
    logic     sy_latch;
    logic     addr;
    logic     rd;
  } dp_cmd_t;

  typedef struct packed {
    logic is_store;
    logic size_zero;
    logic div_done;
    logic hit;
  } dp_stat_t;

  function automatic logic [PIX_W-1:0] swap_outer(input logic [PIX_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16]};
  endfunction

endpackage

### sv/lns_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_divider: iterative restoring divider
// Divides a 26-bit dividend by a 13-bit divisor, one quotient bit per cycle,
// for operands whose quotient fits in 13 bits. done_o pulses with the result.
// ----------------------------------------------------------------------------
module lns_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lns_pkg::PROD_W-1:0] dividend_i,
  input  logic [lns_pkg::SIZE_W-1:0] divisor_i,
  output logic [lns_pkg::SIZE_W-1:0] quot_o,
  output logic                       done_o
);
  import lns_pkg::*;

  localparam int CNT_W = $clog2(SIZE_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SIZE_W - 1);

  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] low_q, low_d;
  logic [SIZE_W-1:0] div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q;
  logic              done_q;
  logic [SIZE_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, low_q[SIZE_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d = fits ? SIZE_W'(trial - {1'b0, div_q}) : trial[SIZE_W-1:0];
    low_d = {low_q[SIZE_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[PROD_W-1:SIZE_W];
      low_q <= dividend_i[SIZE_W-1:0];
      div_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign quot_o = low_q;
  assign done_o = done_q;

endmodule

### sv/lns_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_datapath: geometry, source mapping and image store
// Holds the size registers and the pixel store, and computes the fit
// geometry and source address step by step under controller commands.
// ----------------------------------------------------------------------------
module lns_datapath #(
  parameter int STORE_PIXELS = 65536,
  parameter int COORD_BITS   = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lns_pkg::REG_W-1:0]   cfg_index_i,
  input  logic [lns_pkg::SIZE_W-1:0]  cfg_data_i,
  input  logic                        command_i,
  input  logic [lns_pkg::INDEX_W-1:0] pixel_index_i,
  input  logic [lns_pkg::PIX_W-1:0]   pixel_value_i,
  input  logic [COORD_BITS-1:0]       screen_x_i,
  input  logic [COORD_BITS-1:0]       screen_y_i,
  input  lns_pkg::dp_cmd_t            cmd_i,
  output lns_pkg::dp_stat_t           stat_o,
  output logic [lns_pkg::PIX_W-1:0]   screen_pixel_o,
  output logic                        in_picture_o
);
  import lns_pkg::*;

  localparam int AW    = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
  localparam int CMP_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;

  logic [SIZE_W-1:0] sw_q, sh_q, iw_q, ih_q;
  logic [PIX_W-1:0]  store_mem [STORE_PIXELS];
  logic              cmd_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [PROD_W-1:0] pa_q, pb_q;
  logic              wlim_q;
  logic [SIZE_W-1:0] num_q, den_q;
  logic [PROD_W-1:0] ext_dvd_q;
  logic [SIZE_W-1:0] dx_q, dy_q, ox_q, oy_q;
  logic              inside_q;
  logic [PROD_W-1:0] mx_q, my_q;
  logic [SIZE_W-1:0] sx_q, sy_q;
  logic [SRC_W-1:0]  src_q;
  logic              src_ok_q;
  logic [PIX_W-1:0]  rd_q;

  logic [PROD_W-1:0] div_dvd;
  logic [SIZE_W-1:0] div_dsr;
  logic [SIZE_W-1:0] quot;
  logic              div_done;
  logic [CMP_W-1:0]  x_ext, y_ext, ox_ext, oy_ext, xe_ext, ye_ext;
  logic              inside_d;
  logic [SIZE_W-1:0] rel_x, rel_y;
  logic              idx_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= RST_SCREEN_W;
      sh_q <= RST_SCREEN_H;
      iw_q <= RST_IMAGE_W;
      ih_q <= RST_IMAGE_H;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCREEN_W: sw_q <= cfg_data_i;
        REG_SCREEN_H: sh_q <= cfg_data_i;
        REG_IMAGE_W:  iw_q <= cfg_data_i;
        REG_IMAGE_H:  ih_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign idx_ok = {16'd0, pixel_index_i} < 32'(STORE_PIXELS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && command_i == CMD_STORE && idx_ok) begin
      store_mem[AW'(pixel_index_i)] <= pixel_value_i;
    end
    if (cmd_i.rd) begin
      rd_q <= store_mem[AW'(src_q)];
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_EXT: begin
        div_dvd = ext_dvd_q;
        div_dsr = den_q;
      end
      DIV_SX: begin
        div_dvd = mx_q;
        div_dsr = num_q;
      end
      DIV_SY: begin
        div_dvd = my_q;
        div_dsr = num_q;
      end
      default: begin
        div_dvd = mx_q;
        div_dsr = num_q;
      end
    endcase
  end

  lns_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign x_ext  = CMP_W'(x_q);
  assign y_ext  = CMP_W'(y_q);
  assign ox_ext = CMP_W'(ox_q);
  assign oy_ext = CMP_W'(oy_q);
  assign xe_ext = ox_ext + CMP_W'(dx_q);
  assign ye_ext = oy_ext + CMP_W'(dy_q);
  assign inside_d = (x_ext >= ox_ext) && (x_ext < xe_ext) &&
                    (y_ext >= oy_ext) && (y_ext < ye_ext);
  assign rel_x = SIZE_W'(x_ext - ox_ext);
  assign rel_y = SIZE_W'(y_ext - oy_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= CMD_STORE;
      inside_q <= 1'b0;
    end else if (cmd_i.load) begin
      cmd_q    <= command_i;
      inside_q <= 1'b0;
    end else if (cmd_i.chk) begin
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= screen_x_i;
      y_q <= screen_y_i;
    end
    if (cmd_i.prod) begin
      pa_q <= PROD_W'(sw_q) * PROD_W'(ih_q);
      pb_q <= PROD_W'(sh_q) * PROD_W'(iw_q);
    end
    if (cmd_i.frac) begin
      wlim_q    <= pa_q < pb_q;
      num_q     <= (pa_q < pb_q) ? sw_q : sh_q;
      den_q     <= (pa_q < pb_q) ? iw_q : ih_q;
      ext_dvd_q <= (pa_q < pb_q) ? pa_q : pb_q;
    end
    if (cmd_i.ext_latch) begin
      dx_q <= wlim_q ? sw_q : quot;
      dy_q <= wlim_q ? quot : sh_q;
    end
    if (cmd_i.offs) begin
      ox_q <= SIZE_W'((sw_q - dx_q) >> 1);
      oy_q <= SIZE_W'((sh_q - dy_q) >> 1);
    end
    if (cmd_i.chk) begin
      mx_q <= PROD_W'(rel_x) * PROD_W'(den_q);
      my_q <= PROD_W'(rel_y) * PROD_W'(den_q);
    end
    if (cmd_i.sx_latch) begin
      sx_q <= quot;
    end
    if (cmd_i.sy_latch) begin
      sy_q <= quot;
    end
    if (cmd_i.addr) begin
      src_q <= SRC_W'(sy_q) * SRC_W'(iw_q) + SRC_W'(sx_q);
    end
    if (cmd_i.rd) begin
      src_ok_q <= {{(32 - SRC_W){1'b0}}, src_q} < 32'(STORE_PIXELS);
    end
  end

  assign stat_o.is_store  = cmd_q == CMD_STORE;
  assign stat_o.size_zero = (sw_q == '0) || (sh_q == '0) || (iw_q == '0) || (ih_q == '0);
  assign stat_o.div_done  = div_done;
  assign stat_o.hit       = inside_q;

  assign in_picture_o   = inside_q;
  assign screen_pixel_o = (inside_q && src_ok_q) ? swap_outer(rd_q) : '0;

endmodule

### sv/lns_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lns_ctrl: sequencing state machine
// Steps the datapath through products, scale choice, up to three divisions,
// address and store read, and strobes the result word.
// ----------------------------------------------------------------------------
module lns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lns_pkg::dp_stat_t stat_i,
  output lns_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              valid_o
);
  import lns_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PROD   = 4'd1;
  localparam logic [3:0] S_FRAC   = 4'd2;
  localparam logic [3:0] S_EXT_GO = 4'd3;
  localparam logic [3:0] S_EXT_W  = 4'd4;
  localparam logic [3:0] S_OFS    = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_SX_GO  = 4'd7;
  localparam logic [3:0] S_SX_W   = 4'd8;
  localparam logic [3:0] S_SY_GO  = 4'd9;
  localparam logic [3:0] S_SY_W   = 4'd10;
  localparam logic [3:0] S_ADDR   = 4'd11;
  localparam logic [3:0] S_RD     = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_EXT;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = stat_i.is_store ? S_DONE : (stat_i.size_zero ? S_DONE : S_FRAC);
      end
      S_FRAC: begin
        cmd_o.frac = 1'b1;
        state_d    = S_EXT_GO;
      end
      S_EXT_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_EXT_W;
      end
      S_EXT_W: begin
        if (stat_i.div_done) begin
          cmd_o.ext_latch = 1'b1;
          state_d         = S_OFS;
        end
      end
      S_OFS: begin
        cmd_o.offs = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = S_SX_GO;
      end
      S_SX_GO: begin
        cmd_o.div_sel = DIV_SX;
        if (stat_i.hit) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_SX_W;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SX_W: begin
        cmd_o.div_sel = DIV_SX;
        if (stat_i.div_done) begin
          cmd_o.sx_latch = 1'b1;
          state_d        = S_SY_GO;
        end
      end
      S_SY_GO: begin
        cmd_o.div_sel   = DIV_SY;
        cmd_o.div_start = 1'b1;
        state_d         = S_SY_W;
      end
      S_SY_W: begin
        cmd_o.div_sel = DIV_SY;
        if (stat_i.div_done) begin
          cmd_o.sy_latch = 1'b1;
          state_d        = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = state_q != S_IDLE;
  assign valid_o = state_q == S_DONE;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not raise busy");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (state_q == S_EXT_W || state_q == S_SX_W || state_q == S_SY_W))
    else $error("divider finished outside a wait state");

  a_div_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !stat_i.div_done)
    else $error("divider done right after start");

endmodule

### sv/letterbox_nearest_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler: aspect-fit nearest-neighbor screen pixel reader
// Stores a source RGB image and answers single screen-pixel reads for a
// centered, aspect-preserving fit with the outer bytes swapped.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A store word or a read
// with a zero size keeps busy high only through the product and done states.
// A read in the picture keeps it high through three 13-step divisions (drawn
// extent, source column, source row) run one after another on a single shared
// divider; a read outside the picture stops after the first division. The result
// is valid on the result ports for one cycle with result_valid_o high and cannot
// be stalled. The user must write the size registers through the cfg port only
// while busy is low; the block does not enforce it. There is no clearing pass.
// ----------------------------------------------------------------------------
module letterbox_nearest_scaler #(
  parameter int STORE_PIXELS = 65536,
  parameter int COORD_BITS   = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [lns_pkg::INDEX_W-1:0] pixel_index_i,
  input  logic [lns_pkg::PIX_W-1:0]   pixel_value_i,
  input  logic [COORD_BITS-1:0]       screen_x_i,
  input  logic [COORD_BITS-1:0]       screen_y_i,
  output logic                        result_valid_o,
  output logic [lns_pkg::PIX_W-1:0]   screen_pixel_o,
  output logic                        in_picture_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lns_pkg::REG_W-1:0]   cfg_index_i,
  input  logic [lns_pkg::SIZE_W-1:0]  cfg_data_i
);
  import lns_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lns_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (result_valid_o)
  );

  lns_datapath #(
    .STORE_PIXELS (STORE_PIXELS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .pixel_index_i  (pixel_index_i),
    .pixel_value_i  (pixel_value_i),
    .screen_x_i     (screen_x_i),
    .screen_y_i     (screen_y_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .screen_pixel_o (screen_pixel_o),
    .in_picture_o   (in_picture_o)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: letterbox_nearest_scaler testbench
// Checks the block against a behavioral copy of the aspect-fit mapping that
// keeps its own image store and size registers. A table of directed words
// comes first: reset sizes, edges of the drawn area, a zero size, the largest
// and smallest scales, reads that land beyond the store, and equal scales.
// Random phases follow, each with new sizes. Any read that would land on an
// unwritten store entry is preceded by a store to that entry. Every result
// is compared with the oldest expected word.
// ----------------------------------------------------------------------------
module tb_top;
  import lns_pkg::*;

  localparam int STORE_PIXELS = 65536;
  localparam int COORD_BITS   = 12;
  localparam int ITEM_TARGET  = 1300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 64;

  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             in_pic;
  } screen_word_t;

  typedef enum logic {
    ROW_WORD,
    ROW_SIZE
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               cmd;
    logic [INDEX_W-1:0] idx;
    logic [PIX_W-1:0]   value;
    coord_t             x;
    coord_t             y;
    logic [REG_W-1:0]   reg_idx;
    size_t              reg_data;
    logic               fixed;
    screen_word_t       fixed_word;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               command_i;
  logic [INDEX_W-1:0] pixel_index_i;
  logic [PIX_W-1:0]   pixel_value_i;
  coord_t             screen_x_i;
  coord_t             screen_y_i;
  logic               result_valid_o;
  logic [PIX_W-1:0]   screen_pixel_o;
  logic               in_picture_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [REG_W-1:0]   cfg_index_i;
  size_t              cfg_data_i;

  logic [PIX_W-1:0] image_mem [STORE_PIXELS];
  bit               written   [STORE_PIXELS];
  size_t            size_reg  [4];

  screen_word_t pending_pixels [$];
  stim_row_t    directed_rows  [$];
  int           mismatches  = 0;
  int           words_sent  = 0;
  int           burst_left  = 0;
  int           idle_cycles = 0;

  letterbox_nearest_scaler #(
    .STORE_PIXELS(STORE_PIXELS),
    .COORD_BITS  (COORD_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .pixel_index_i (pixel_index_i),
    .pixel_value_i (pixel_value_i),
    .screen_x_i    (screen_x_i),
    .screen_y_i    (screen_y_i),
    .result_valid_o(result_valid_o),
    .screen_pixel_o(screen_pixel_o),
    .in_picture_o  (in_picture_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Maps a screen coordinate to a linear source index under the current sizes.
  function automatic void locate_source(input coord_t x, input coord_t y,
                                        output logic hit,
                                        output logic [SRC_W-1:0] src);
    size_t             sw, sh, iw, ih, num, den, dx, dy, ox, oy, col, row, xs, ys;
    logic [PROD_W-1:0] cross_w, cross_h, span, sx, sy;
    sw = size_reg[REG_SCREEN_W];
    sh = size_reg[REG_SCREEN_H];
    iw = size_reg[REG_IMAGE_W];
    ih = size_reg[REG_IMAGE_H];
    xs = size_t'(x);
    ys = size_t'(y);
    hit = 1'b0;
    src = '0;
    if (sw == 0 || sh == 0 || iw == 0 || ih == 0) return;
    cross_w = PROD_W'(sw) * PROD_W'(ih);
    cross_h = PROD_W'(sh) * PROD_W'(iw);
    if (cross_w < cross_h) begin
      num = sw;
      den = iw;
    end else begin
      num = sh;
      den = ih;
    end
    span = PROD_W'(iw) * PROD_W'(num);
    dx   = size_t'(span / PROD_W'(den));
    span = PROD_W'(ih) * PROD_W'(num);
    dy   = size_t'(span / PROD_W'(den));
    ox   = (sw - dx) >> 1;
    oy   = (sh - dy) >> 1;
    if (xs < ox || xs >= ox + dx || ys < oy || ys >= oy + dy) return;
    col  = xs - ox;
    row  = ys - oy;
    span = PROD_W'(col) * PROD_W'(den);
    sx   = span / PROD_W'(num);
    span = PROD_W'(row) * PROD_W'(den);
    sy   = span / PROD_W'(num);
    src  = SRC_W'(sy) * SRC_W'(iw) + SRC_W'(sx);
    hit  = 1'b1;
  endfunction

  function automatic screen_word_t predict_screen_word(input logic cmd,
                                                       input logic [INDEX_W-1:0] idx,
                                                       input logic [PIX_W-1:0] value,
                                                       input coord_t x,
                                                       input coord_t y);
    screen_word_t     w;
    logic             hit;
    logic [SRC_W-1:0] src;
    logic [PIX_W-1:0] p;
    w = '0;
    if (cmd == CMD_STORE) begin
      image_mem[idx] = value;
      written[idx]   = 1'b1;
      return w;
    end
    locate_source(x, y, hit, src);
    if (hit) begin
      w.in_pic = 1'b1;
      if (src < STORE_PIXELS) begin
        p       = image_mem[src[INDEX_W-1:0]];
        w.pixel = {p[7:0], p[15:8], p[23:16]};
      end
    end
    return w;
  endfunction

  function automatic stim_row_t store_row(input logic [INDEX_W-1:0] idx,
                                          input logic [PIX_W-1:0] value);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WORD;
    r.cmd   = CMD_STORE;
    r.idx   = idx;
    r.value = value;
    r.fixed = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t read_row(input coord_t x, input coord_t y);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WORD;
    r.cmd  = CMD_READ;
    r.x    = x;
    r.y    = y;
    r.idx  = INDEX_W'($urandom);
    r.value = PIX_W'($urandom);
    return r;
  endfunction

  function automatic stim_row_t check_row(input coord_t x, input coord_t y,
                                          input logic [PIX_W-1:0] pixel,
                                          input logic in_pic);
    stim_row_t r;
    r                   = read_row(x, y);
    r.fixed             = 1'b1;
    r.fixed_word.pixel  = pixel;
    r.fixed_word.in_pic = in_pic;
    return r;
  endfunction

  function automatic stim_row_t size_row(input logic [REG_W-1:0] i, input size_t d);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_SIZE;
    r.reg_idx  = i;
    r.reg_data = d;
    return r;
  endfunction

  function automatic coord_t pick_coord(input size_t lim);
    int top;
    if (lim == 0 || $urandom_range(0, 4) == 0) return coord_t'($urandom);
    top = (lim > 4096) ? 4095 : int'(lim) - 1;
    return coord_t'($urandom_range(0, top));
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_word(input stim_row_t r);
    screen_word_t w;
    int           gap;
    command_i     <= r.cmd;
    pixel_index_i <= r.idx;
    pixel_value_i <= r.value;
    screen_x_i    <= r.x;
    screen_y_i    <= r.y;
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    w = predict_screen_word(r.cmd, r.idx, r.value, r.x, r.y);
    pending_pixels.push_back(r.fixed ? r.fixed_word : w);
    words_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_pixels.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [REG_W-1:0] i, input size_t d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= i;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    size_reg[i] = d;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int n);
    size_t            s [4];
    stim_row_t        r;
    logic             hit;
    logic [SRC_W-1:0] src;
    int               area;
    int               mult;
    logic [INDEX_W-1:0] idx;
    case ($urandom_range(0, 9))
      0: begin
        for (int i = 0; i < 4; i++) s[i] = $urandom_range(0, 1) ? 13'd4096 : 13'd1;
      end
      1: begin
        for (int i = 0; i < 4; i++) s[i] = size_t'($urandom_range(1, 4096));
        s[$urandom_range(0, 3)] = '0;
      end
      2: begin
        s[REG_SCREEN_W] = size_t'($urandom_range(1, 4096));
        s[REG_SCREEN_H] = size_t'($urandom_range(1, 4096));
        s[REG_IMAGE_W]  = size_t'($urandom_range(1024, 4096));
        s[REG_IMAGE_H]  = size_t'($urandom_range(1024, 4096));
      end
      3: begin
        mult            = $urandom_range(1, 8);
        s[REG_IMAGE_W]  = size_t'($urandom_range(1, 64));
        s[REG_IMAGE_H]  = size_t'($urandom_range(1, 64));
        s[REG_SCREEN_W] = size_t'(int'(s[REG_IMAGE_W]) * mult);
        s[REG_SCREEN_H] = size_t'(int'(s[REG_IMAGE_H]) * mult);
      end
      default: begin
        s[REG_SCREEN_W] = size_t'($urandom_range(1, 200));
        s[REG_SCREEN_H] = size_t'($urandom_range(1, 200));
        s[REG_IMAGE_W]  = size_t'($urandom_range(1, 128));
        s[REG_IMAGE_H]  = size_t'($urandom_range(1, 128));
      end
    endcase
    drain_results();
    write_size(REG_SCREEN_W, s[REG_SCREEN_W]);
    write_size(REG_SCREEN_H, s[REG_SCREEN_H]);
    write_size(REG_IMAGE_W, s[REG_IMAGE_W]);
    write_size(REG_IMAGE_H, s[REG_IMAGE_H]);
    area = int'(size_reg[REG_IMAGE_W]) * int'(size_reg[REG_IMAGE_H]);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 && $urandom_range(0, 3) == 0) drain_results();
      if ($urandom_range(0, 3) == 0) begin
        if (area > 0 && $urandom_range(0, 1) == 1)
          idx = INDEX_W'($urandom_range(0, (area < STORE_PIXELS) ? area - 1
                                                                 : STORE_PIXELS - 1));
        else
          idx = INDEX_W'($urandom);
        send_word(store_row(idx, PIX_W'($urandom)));
      end else begin
        r = read_row(pick_coord(size_reg[REG_SCREEN_W]), pick_coord(size_reg[REG_SCREEN_H]));
        locate_source(r.x, r.y, hit, src);
        // fill the mapped entry first so no read sees an unwritten pixel
        if (hit && src < STORE_PIXELS && !written[src[INDEX_W-1:0]])
          send_word(store_row(src[INDEX_W-1:0], PIX_W'($urandom)));
        send_word(r);
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    screen_word_t exp_w;
    if (rst_ni && result_valid_o) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: screen_pixel %h in_picture %b",
               screen_pixel_o, in_picture_o);
        mismatches++;
      end else begin
        exp_w = pending_pixels.pop_front();
        if (screen_pixel_o !== exp_w.pixel) begin
          $error("screen_pixel: expected %h, got %h", exp_w.pixel, screen_pixel_o);
          mismatches++;
        end
        if (in_picture_o !== exp_w.in_pic) begin
          $error("in_picture: expected %b, got %b", exp_w.in_pic, in_picture_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("letterbox_nearest_scaler test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_STORE;
    pixel_index_i = '0;
    pixel_value_i = '0;
    screen_x_i    = '0;
    screen_y_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SCREEN_W;
    cfg_data_i    = '0;
    size_reg[REG_SCREEN_W] = RST_SCREEN_W;
    size_reg[REG_SCREEN_H] = RST_SCREEN_H;
    size_reg[REG_IMAGE_W]  = RST_IMAGE_W;
    size_reg[REG_IMAGE_H]  = RST_IMAGE_H;

    // reset sizes: 480/256 scale, picture at x 160..639, full height
    directed_rows.push_back(store_row(16'd0, 24'h123456));
    directed_rows.push_back(check_row(12'd0, 12'd0, 24'h0, 1'b0));
    directed_rows.push_back(check_row(12'd160, 12'd0, 24'h563412, 1'b1));
    directed_rows.push_back(store_row(16'hFFFF, 24'hFFFFFF));
    directed_rows.push_back(check_row(12'd639, 12'd479, 24'hFFFFFF, 1'b1));
    directed_rows.push_back(check_row(12'd640, 12'd0, 24'h0, 1'b0));
    directed_rows.push_back(check_row(12'hFFF, 12'hFFF, 24'h0, 1'b0));
    directed_rows.push_back(store_row(16'hFF00, 24'hABCDEF));
    directed_rows.push_back(check_row(12'd160, 12'd479, 24'hEFCDAB, 1'b1));
    directed_rows.push_back(store_row(16'd1, 24'h000000));
    directed_rows.push_back(read_row(12'd161, 12'd0));
    directed_rows.push_back(read_row(12'd162, 12'd0));
    // zero size
    directed_rows.push_back(size_row(REG_SCREEN_W, 13'd0));
    directed_rows.push_back(check_row(12'd200, 12'd100, 24'h0, 1'b0));
    // 1x1 image blown up to the largest screen
    directed_rows.push_back(size_row(REG_SCREEN_W, 13'd4096));
    directed_rows.push_back(size_row(REG_SCREEN_H, 13'd4096));
    directed_rows.push_back(size_row(REG_IMAGE_W, 13'd1));
    directed_rows.push_back(size_row(REG_IMAGE_H, 13'd1));
    directed_rows.push_back(check_row(12'd0, 12'd0, 24'h563412, 1'b1));
    directed_rows.push_back(check_row(12'hFFF, 12'hFFF, 24'h563412, 1'b1));
    // largest image on a 1x1 screen
    directed_rows.push_back(size_row(REG_SCREEN_W, 13'd1));
    directed_rows.push_back(size_row(REG_SCREEN_H, 13'd1));
    directed_rows.push_back(size_row(REG_IMAGE_W, 13'd4096));
    directed_rows.push_back(size_row(REG_IMAGE_H, 13'd4096));
    directed_rows.push_back(check_row(12'd0, 12'd0, 24'h563412, 1'b1));
    directed_rows.push_back(check_row(12'd1, 12'd0, 24'h0, 1'b0));
    // unit scale, source index past the store
    directed_rows.push_back(size_row(REG_SCREEN_W, 13'd4096));
    directed_rows.push_back(size_row(REG_SCREEN_H, 13'd4096));
    directed_rows.push_back(check_row(12'hFFF, 12'hFFF, 24'h0, 1'b1));
    directed_rows.push_back(check_row(12'd0, 12'd16, 24'h0, 1'b1));
    directed_rows.push_back(check_row(12'hFFF, 12'd15, 24'hFFFFFF, 1'b1));
    // equal scales on both axes
    directed_rows.push_back(size_row(REG_SCREEN_W, 13'd800));
    directed_rows.push_back(size_row(REG_SCREEN_H, 13'd480));
    directed_rows.push_back(size_row(REG_IMAGE_W, 13'd400));
    directed_rows.push_back(size_row(REG_IMAGE_H, 13'd240));
    directed_rows.push_back(check_row(12'd1, 12'd1, 24'h563412, 1'b1));
    directed_rows.push_back(read_row(12'd799, 12'd479));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_SIZE) begin
        drain_results();
        write_size(directed_rows[k].reg_idx, directed_rows[k].reg_data);
      end else begin
        send_word(directed_rows[k]);
      end
    end

    while (words_sent < ITEM_TARGET) run_phase($urandom_range(40, 160));

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("letterbox_nearest_scaler test passed");
    end else begin
      $display("letterbox_nearest_scaler test failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/lns_pkg.sv
sv/lns_divider.sv
sv/lns_datapath.sv
sv/lns_ctrl.sv
sv/letterbox_nearest_scaler.sv
test/tb_top.sv
